// ===== rtl/huffman_code_bit_packer_core_assert.svh =====
// Assertion macros used by the checker file of the Huffman bit packer
`ifndef HUFFMAN_CODE_BIT_PACKER_CORE_ASSERT_SVH
`define HUFFMAN_CODE_BIT_PACKER_CORE_ASSERT_SVH

// same-cycle implication
`define HCBP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HCBP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/hcbp_pkg.sv =====
// Shared constants and types of the Huffman code bit packer
package hcbp_pkg;

  localparam int MAX_CODE_LEN  = 32;
  localparam int ALPHABET_SIZE = 256;
  localparam int LEN_CAP       = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;

  localparam int SYM_W  = 8;
  localparam int CODE_W = 32;
  localparam int LEN_W  = 6;
  localparam int ACC_W  = 8;
  localparam int HELD_W = 3;
  localparam int CNT_W  = 32;
  localparam int PAD_W  = 3;
  localparam int WIN_W  = CODE_W + ACC_W;
  localparam int ADDR_W = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;

  localparam int S_TDATA_W = 48;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 48;
  localparam int M_TUSER_W = 2;

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_ENCODE = 2'd1;
  localparam logic [1:0] ACT_FINISH = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [ADDR_W-1:0] addr;
    logic [CODE_W-1:0] wr_code;
    logic [LEN_W-1:0]  wr_len;
  } tbl_req_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic              valid;
  } tbl_rsp_t;

endpackage

// ===== rtl/hcbp_code_table.sv =====
// Code table: codeword and length memory with per-entry valid marks
module hcbp_code_table import hcbp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  tbl_req_t req,
  output tbl_rsp_t rsp
);

  logic [CODE_W+LEN_W-1:0] mem [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0] entry_valid;
  logic [CODE_W+LEN_W-1:0] rd_data;
  logic                    rd_valid;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= {req.wr_code, req.wr_len};
    end
    if (req.rd_en) begin
      rd_data <= mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_valid    <= 1'b0;
    end else begin
      if (req.wr_en) begin
        entry_valid[req.addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid <= entry_valid[req.addr];
      end
    end
  end

  assign rsp.code  = rd_data[CODE_W+LEN_W-1:LEN_W];
  assign rsp.len   = rd_data[LEN_W-1:0];
  assign rsp.valid = rd_valid;

endmodule

// ===== rtl/huffman_code_bit_packer_core.sv =====
// Top level of the Huffman code bit packer: item decode, bit window and output register
//
// Input items arrive on s_tvalid/s_tready with the action in s_tuser. A load item
// writes one code table entry. An encode item reads the table, whose response is
// registered, then drains the completed bytes of its bit window one per cycle
// while the receiver takes them (up to 4 bytes; none when no byte completes);
// each byte passes through the window register and then the output register. A
// finish item yields a single result, which is offered from the next cycle.
// Results leave on m_tvalid/m_tready; m_tlast marks the last result of an item.
// Items are taken only while no encode is in progress and the output register
// is empty or being emptied, so a stalled receiver holds the result and stops
// intake; nothing is dropped. Reset clears every valid mark of the code table,
// the bit accumulator, the bit count and the symbol counter; table contents are
// kept as undefined until loaded. No clearing pass is needed after reset.
module huffman_code_bit_packer_core import hcbp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // symbol, code_bits, code_length
  input  logic [S_TUSER_W-1:0] s_tuser,   // action
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // out_byte, pad_bits, symbols_seen
  output logic [M_TUSER_W-1:0] m_tuser,   // byte_valid, error
  output logic                 m_tlast
);

  tbl_req_t treq;
  tbl_rsp_t trsp;

  hcbp_code_table u_table (
    .clk (clk),
    .rst (rst),
    .req (treq),
    .rsp (trsp)
  );

  logic [1:0]        action;
  logic [SYM_W-1:0]  symbol;
  logic [CODE_W-1:0] code_bits;
  logic [LEN_W-1:0]  code_length;
  logic [LEN_W-1:0]  len_cap;
  logic              in_alpha;
  logic              accept;
  logic              slot_free;

  state_t            state, state_next;
  logic [ACC_W-1:0]  acc, acc_next;
  logic [HELD_W-1:0] held, held_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [WIN_W-1:0]  win, win_next;
  logic [LEN_W-1:0]  total, total_next;
  logic              sym_ok, sym_ok_next;

  logic              ovalid, ovalid_next;
  logic [ACC_W-1:0]  obyte, obyte_next;
  logic              obv, obv_next;
  logic [PAD_W-1:0]  opad, opad_next;
  logic [CNT_W-1:0]  oseen, oseen_next;
  logic              oerr, oerr_next;
  logic              olast, olast_next;

  logic [WIN_W-1:0]  comb_win;
  logic [LEN_W-1:0]  comb_total;
  logic              push;

  assign action      = s_tuser[1:0];
  assign symbol      = s_tdata[SYM_W-1:0];
  assign code_bits   = s_tdata[SYM_W+CODE_W-1:SYM_W];
  assign code_length = s_tdata[SYM_W+CODE_W+LEN_W-1:SYM_W+CODE_W];

  assign len_cap   = (code_length > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : code_length;
  assign in_alpha  = {1'b0, symbol} < (SYM_W+1)'(ALPHABET_SIZE);
  assign slot_free = !ovalid || m_tready;
  assign s_tready  = (state == ST_IDLE) && slot_free;
  assign accept    = s_tvalid && s_tready;

  assign treq.rd_en   = accept && (action == ACT_ENCODE);
  assign treq.wr_en   = accept && (action == ACT_LOAD) && in_alpha;
  assign treq.addr    = symbol[ADDR_W-1:0];
  assign treq.wr_code = code_bits << (LEN_W'(CODE_W) - len_cap);
  assign treq.wr_len  = len_cap;

  assign comb_win   = {acc, {CODE_W{1'b0}}} | ({trsp.code, {ACC_W{1'b0}}} >> held);
  assign comb_total = {{(LEN_W-HELD_W){1'b0}}, held} + trsp.len;

  always_comb begin
    state_next  = state;
    acc_next    = acc;
    held_next   = held;
    count_next  = count;
    win_next    = win;
    total_next  = total;
    sym_ok_next = sym_ok;
    push        = 1'b0;
    obyte_next  = obyte;
    obv_next    = obv;
    opad_next   = opad;
    oseen_next  = oseen;
    oerr_next   = oerr;
    olast_next  = olast;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (action)
            ACT_ENCODE: begin
              sym_ok_next = in_alpha;
              state_next  = ST_LOOKUP;
            end
            ACT_FINISH: begin
              push       = 1'b1;
              obyte_next = acc;
              obv_next   = (held != '0);
              opad_next  = (held != '0) ? PAD_W'(4'd8 - {1'b0, held}) : '0;
              oseen_next = count;
              oerr_next  = 1'b0;
              olast_next = 1'b1;
              acc_next   = '0;
              held_next  = '0;
              count_next = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_LOOKUP: begin
        if (!(sym_ok && trsp.valid)) begin
          if (slot_free) begin
            push       = 1'b1;
            obyte_next = '0;
            obv_next   = 1'b0;
            opad_next  = '0;
            oseen_next = '0;
            oerr_next  = 1'b1;
            olast_next = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          count_next = (count != '1) ? count + 1'b1 : count;
          if (comb_total < LEN_W'(ACC_W)) begin
            acc_next   = comb_win[WIN_W-1 -: ACC_W];
            held_next  = comb_total[HELD_W-1:0];
            state_next = ST_IDLE;
          end else begin
            win_next   = comb_win;
            total_next = comb_total;
            state_next = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          push       = 1'b1;
          obyte_next = win[WIN_W-1 -: ACC_W];
          obv_next   = 1'b1;
          opad_next  = '0;
          oseen_next = '0;
          oerr_next  = 1'b0;
          olast_next = (total < LEN_W'(2*ACC_W));
          win_next   = win << ACC_W;
          total_next = total - LEN_W'(ACC_W);
          if (total < LEN_W'(2*ACC_W)) begin
            acc_next   = win[WIN_W-ACC_W-1 -: ACC_W];
            held_next  = total[HELD_W-1:0];
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    ovalid_next = push ? 1'b1 : (m_tready ? 1'b0 : ovalid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      acc    <= '0;
      held   <= '0;
      count  <= '0;
      ovalid <= 1'b0;
    end else begin
      state  <= state_next;
      acc    <= acc_next;
      held   <= held_next;
      count  <= count_next;
      ovalid <= ovalid_next;
    end
  end

  always_ff @(posedge clk) begin
    win    <= win_next;
    total  <= total_next;
    sym_ok <= sym_ok_next;
    obyte  <= obyte_next;
    obv    <= obv_next;
    opad   <= opad_next;
    oseen  <= oseen_next;
    oerr   <= oerr_next;
    olast  <= olast_next;
  end

  assign m_tvalid = ovalid;
  assign m_tdata  = {{(M_TDATA_W-ACC_W-PAD_W-CNT_W){1'b0}}, oseen, opad, obyte};
  assign m_tuser  = {oerr, obv};
  assign m_tlast  = olast;

endmodule

// ===== rtl/hcbp_checker.sv =====
// Port-level checker of the Huffman code bit packer and its bind
`include "huffman_code_bit_packer_core_assert.svh"

module hcbp_checker import hcbp_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic [S_TDATA_W-1:0] s_tdata,
  input logic [S_TUSER_W-1:0] s_tuser,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic [M_TUSER_W-1:0] m_tuser,
  input logic                 m_tlast
);

  `HCBP_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled item changed")
  `HCBP_ASSERT_NOW(a_err_alone, clk, rst, m_tvalid && m_tuser[1], m_tlast && !m_tuser[0] && (m_tdata == '0), "error item carries data")
  `HCBP_ASSERT_NOW(a_pad_finish, clk, rst, m_tvalid && (m_tdata[10:8] != 3'd0), m_tuser[0] && m_tlast, "padding outside a flushed byte")
  `HCBP_ASSERT_NOW(a_no_intake_stall, clk, rst, m_tvalid && !m_tready, !s_tready, "intake while output stalled")

endmodule

bind huffman_code_bit_packer_core hcbp_checker u_hcbp_checker (.*);
